// ----- design/otid_pkg.sv -----
// Shared constants for the insert/delete edit transform block.
package otid_pkg;

    localparam int POS_WIDTH_DEF  = 24;
    localparam int USER_WIDTH_DEF = 16;

    // Edit operation kinds
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

endpackage

// ----- design/ot_transform_insert_delete.sv -----
// Transform of two concurrent insert/delete edits into each other's context.
// Path: accepted request -> input register -> one pass of compare/add logic -> result register.
// Throughput: one request per cycle while the output is not stalled.
// Reset: synchronous active-low i_rst_n empties both stages; no configuration, no stored state.
// Stall from the output side backs up through the result and input registers.
module ot_transform_insert_delete
    import otid_pkg::*;
#(
    parameter int POS_WIDTH  = POS_WIDTH_DEF,
    parameter int USER_WIDTH = USER_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_first_type,
    input  logic [POS_WIDTH-1:0]  i_first_pos,
    input  logic [POS_WIDTH-1:0]  i_first_len,
    input  logic [USER_WIDTH-1:0] i_first_user,
    input  logic                  i_second_type,
    input  logic [POS_WIDTH-1:0]  i_second_pos,
    input  logic [POS_WIDTH-1:0]  i_second_len,
    input  logic [USER_WIDTH-1:0] i_second_user,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [POS_WIDTH-1:0]  o_first_pos_out,
    output logic [POS_WIDTH-1:0]  o_first_len_out,
    output logic [POS_WIDTH-1:0]  o_second_pos_out,
    output logic [POS_WIDTH-1:0]  o_second_len_out
);

    localparam int W = POS_WIDTH;
    localparam logic [W-1:0] POS_MAX = {W{1'b1}};

    // ---------------- stage 1: input register ----------------
    logic                  r_s1_valid;
    logic                  r_s1_first_type;
    logic [W-1:0]          r_s1_first_pos;
    logic [W-1:0]          r_s1_first_len;
    logic [USER_WIDTH-1:0] r_s1_first_user;
    logic                  r_s1_second_type;
    logic [W-1:0]          r_s1_second_pos;
    logic [W-1:0]          r_s1_second_len;
    logic [USER_WIDTH-1:0] r_s1_second_user;

    logic                  r_out_valid;
    logic [W-1:0]          r_out_first_pos;
    logic [W-1:0]          r_out_first_len;
    logic [W-1:0]          r_out_second_pos;
    logic [W-1:0]          r_out_second_len;

    logic in_accept;
    logic s1_move;

    assign s1_move    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_move;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_first_type  <= i_first_type;
            r_s1_first_pos   <= i_first_pos;
            r_s1_first_len   <= i_first_len;
            r_s1_first_user  <= i_first_user;
            r_s1_second_type <= i_second_type;
            r_s1_second_pos  <= i_second_pos;
            r_s1_second_len  <= i_second_len;
            r_s1_second_user <= i_second_user;
        end
    end

    // ---------------- transform logic ----------------
    logic [W-1:0] pa, la, pb, lb;
    assign pa = r_s1_first_pos;
    assign la = r_s1_first_len;
    assign pb = r_s1_second_pos;
    assign lb = r_s1_second_len;

    // insert vs insert
    logic         ii_a_first, ii_b_first;
    logic [W:0]   ii_b_sum, ii_a_sum;
    logic [W-1:0] ii_b_pos, ii_a_pos;

    assign ii_a_first = (pa < pb) || (pa == pb && r_s1_first_user < r_s1_second_user);
    assign ii_b_first = (pa > pb) || (pa == pb && r_s1_first_user > r_s1_second_user);
    assign ii_b_sum   = {1'b0, pb} + {1'b0, la};
    assign ii_a_sum   = {1'b0, pa} + {1'b0, lb};
    assign ii_b_pos   = ii_b_sum[W] ? POS_MAX : ii_b_sum[W-1:0];
    assign ii_a_pos   = ii_a_sum[W] ? POS_MAX : ii_a_sum[W-1:0];

    // insert vs delete, with the operands steered into insert/delete roles
    logic         ins_is_first;
    logic [W-1:0] id_pi, id_li, id_pd, id_ld;
    logic [W:0]   id_end, id_dpos_sum, id_dlen_sum;
    logic [W-1:0] id_ins_pos, id_ins_len, id_del_pos, id_del_len;

    assign ins_is_first = (r_s1_first_type == OP_INSERT);
    assign id_pi = ins_is_first ? pa : pb;
    assign id_li = ins_is_first ? la : lb;
    assign id_pd = ins_is_first ? pb : pa;
    assign id_ld = ins_is_first ? lb : la;

    assign id_end      = {1'b0, id_pd} + {1'b0, id_ld};
    assign id_dpos_sum = {1'b0, id_pd} + {1'b0, id_li};
    assign id_dlen_sum = {1'b0, id_ld} + {1'b0, id_li};

    always_comb begin
        id_ins_pos = id_pi;
        id_ins_len = id_li;
        id_del_pos = id_pd;
        id_del_len = id_ld;
        priority if (id_pi <= id_pd) begin
            id_del_pos = id_dpos_sum[W] ? POS_MAX : id_dpos_sum[W-1:0];
        end else if ({1'b0, id_pi} >= id_end) begin
            id_ins_pos = id_pi - id_ld;
        end else begin
            // insert lands strictly inside the deleted range: absorbed
            id_del_len = id_dlen_sum[W] ? POS_MAX : id_dlen_sum[W-1:0];
            id_ins_pos = id_pd;
            id_ins_len = '0;
        end
    end

    // delete vs delete
    logic [W:0]   dd_ea, dd_eb, dd_lo_end, dd_hi_start, dd_ov_full;
    logic         dd_overlap;
    logic [W-1:0] dd_ov, dd_lo_pos, dd_gap_b, dd_gap_a, dd_b_pull, dd_a_pull;

    assign dd_ea       = {1'b0, pa} + {1'b0, la};
    assign dd_eb       = {1'b0, pb} + {1'b0, lb};
    assign dd_lo_end   = (dd_ea < dd_eb) ? dd_ea : dd_eb;
    assign dd_hi_start = {1'b0, (pa > pb) ? pa : pb};
    assign dd_overlap  = dd_lo_end > dd_hi_start;
    assign dd_ov_full  = dd_lo_end - dd_hi_start;
    assign dd_ov       = dd_ov_full[W-1:0];    // never exceeds either length
    assign dd_lo_pos   = (pa < pb) ? pa : pb;
    // empty delete sitting inside the other range clamps to that range's start
    assign dd_gap_b    = pb - pa;
    assign dd_gap_a    = pa - pb;
    assign dd_b_pull   = (dd_gap_b < la) ? pa : pb - la;
    assign dd_a_pull   = (dd_gap_a < lb) ? pb : pa - lb;

    logic [W-1:0] n_first_pos, n_first_len, n_second_pos, n_second_len;

    always_comb begin
        n_first_pos  = pa;
        n_first_len  = la;
        n_second_pos = pb;
        n_second_len = lb;
        unique case ({r_s1_first_type, r_s1_second_type})
            {OP_INSERT, OP_INSERT}: begin
                if (ii_a_first) begin
                    n_second_pos = ii_b_pos;
                end else if (ii_b_first) begin
                    n_first_pos = ii_a_pos;
                end
            end
            {OP_INSERT, OP_DELETE}: begin
                n_first_pos  = id_ins_pos;
                n_first_len  = id_ins_len;
                n_second_pos = id_del_pos;
                n_second_len = id_del_len;
            end
            {OP_DELETE, OP_INSERT}: begin
                n_first_pos  = id_del_pos;
                n_first_len  = id_del_len;
                n_second_pos = id_ins_pos;
                n_second_len = id_ins_len;
            end
            default: begin
                if (dd_overlap) begin
                    n_first_pos  = dd_lo_pos;
                    n_second_pos = dd_lo_pos;
                    n_first_len  = la - dd_ov;
                    n_second_len = lb - dd_ov;
                end else if (pa < pb) begin
                    n_second_pos = dd_b_pull;
                end else if (pa > pb) begin
                    n_first_pos = dd_a_pull;
                end
            end
        endcase
    end

    // ---------------- stage 2: result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_first_pos  <= n_first_pos;
            r_out_first_len  <= n_first_len;
            r_out_second_pos <= n_second_pos;
            r_out_second_len <= n_second_len;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_first_pos_out  = r_out_first_pos;
    assign o_first_len_out  = r_out_first_len;
    assign o_second_pos_out = r_out_second_pos;
    assign o_second_len_out = r_out_second_len;

`ifndef SYNTHESIS
    // Stall only when both stages hold a request and the output is blocked
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled while a stage was free");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_s1_valid)
        else $error("accepted request not held in input stage");

    a_move_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move |=> r_out_valid)
        else $error("request lost between input and result stage");

    // Two inserts never change each other's length
    a_ins_ins_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && r_s1_first_type == OP_INSERT && r_s1_second_type == OP_INSERT)
        |=> (o_first_len_out == $past(r_s1_first_len)
             && o_second_len_out == $past(r_s1_second_len)))
        else $error("insert length altered by insert transform");

    // Overlapping deletes collapse to a common start
    a_del_overlap_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && r_s1_first_type == OP_DELETE && r_s1_second_type == OP_DELETE
         && dd_overlap)
        |=> (o_first_pos_out == o_second_pos_out))
        else $error("overlapping deletes not moved to common start");
`endif

endmodule
